FILE: hw/rtl/izb_pkg.sv
`default_nettype none
package izb_pkg;

  // Input item: store or render
  typedef struct packed {
    logic        action;
    logic [15:0] source_index;
    logic [7:0]  byte_0;
    logic [7:0]  byte_1;
    logic [7:0]  byte_2;
    logic [11:0] dest_x;
    logic [11:0] dest_y;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [31:0] pixel_color;
    logic        outside_image;
  } out_item_t;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_PAN_X      = 3'd2,
    REG_PAN_Y      = 3'd3,
    REG_INV_ZOOM   = 3'd4,
    REG_BPP        = 3'd5,
    REG_BG_COLOR   = 3'd6,
    REG_IMG_PRES   = 3'd7
  } cfg_reg_t;

  localparam logic ACT_STORE  = 1'b0;
  localparam logic ACT_RENDER = 1'b1;

  localparam int STORE_AW    = 16;
  localparam int STORE_DEPTH = 1 << STORE_AW;

endpackage
`default_nettype wire

FILE: hw/rtl/image_zoom_bilinear.sv
// Bilinear zoom with pan. Store items write one source pixel into the
// frame store; render items produce one ARGB pixel each. One item is
// accepted every clock (busy is never raised). A render result is on out_item
// with out_valid for one cycle, once its item has passed through the four
// pipeline stages and the output register. A store produces no result. The
// receiver cannot stall, so every strobe must be captured.
// The frame store is held as four identical single-port copies, one per
// bilinear neighbour, so all four reads happen in one cycle. A store written
// in one cycle is seen by any render that follows it. Store contents are
// undefined until written; there is no clearing pass after reset.
`default_nettype none
module image_zoom_bilinear #(
  parameter int MAX_DEST_WIDTH  = 4096,
  parameter int MAX_DEST_HEIGHT = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire izb_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output izb_pkg::out_item_t      out_item,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_wdata
);
  import izb_pkg::*;

  // Configuration registers
  logic [8:0]  src_width_r, src_height_r;
  logic [15:0] pan_x_r, pan_y_r;
  logic [23:0] inv_zoom_r;
  logic [2:0]  bpp_r;
  logic [31:0] bg_color_r;
  logic        img_pres_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= 9'd256;
      src_height_r <= 9'd256;
      pan_x_r      <= '0;
      pan_y_r      <= '0;
      inv_zoom_r   <= 24'd65536;
      bpp_r        <= 3'd1;
      bg_color_r   <= '0;
      img_pres_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SRC_WIDTH:  src_width_r  <= cfg_wdata[8:0];
        REG_SRC_HEIGHT: src_height_r <= cfg_wdata[8:0];
        REG_PAN_X:      pan_x_r      <= cfg_wdata[15:0];
        REG_PAN_Y:      pan_y_r      <= cfg_wdata[15:0];
        REG_INV_ZOOM:   inv_zoom_r   <= cfg_wdata[23:0];
        REG_BPP:        bpp_r        <= cfg_wdata[2:0];
        REG_BG_COLOR:   bg_color_r   <= cfg_wdata;
        REG_IMG_PRES:   img_pres_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;
  logic in_xfer;
  assign in_xfer = start && !busy;

  // Stage 1: capture item
  logic     s1_vld_r;
  in_item_t s1_item_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= in_xfer;
    s1_item_r <= in_item;
  end

  // Stage 1 -> 2: pixel-center mapping, p = (2d+1) * inv_zoom
  logic signed [16:0] dx_s, dy_s;
  logic signed [17:0] ox_s, oy_s;
  logic signed [42:0] px_nxt, py_nxt;
  logic               range_ok;
  always_comb begin
    dx_s   = $signed({5'b0, s1_item_r.dest_x}) - 17'(signed'(pan_x_r));
    dy_s   = $signed({5'b0, s1_item_r.dest_y}) - 17'(signed'(pan_y_r));
    ox_s   = 18'(dx_s) * 18'sd2 + 18'sd1;
    oy_s   = 18'(dy_s) * 18'sd2 + 18'sd1;
    px_nxt = 43'(ox_s) * $signed({19'b0, inv_zoom_r});
    py_nxt = 43'(oy_s) * $signed({19'b0, inv_zoom_r});
    range_ok = ({20'b0, s1_item_r.dest_x} < 32'(MAX_DEST_WIDTH)) &&
               ({20'b0, s1_item_r.dest_y} < 32'(MAX_DEST_HEIGHT));
  end

  logic               s2_vld_r, s2_ok_r;
  in_item_t           s2_item_r;
  logic signed [42:0] s2_px_r, s2_py_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
    s2_item_r <= s1_item_r;
    s2_ok_r   <= range_ok && img_pres_r;
    s2_px_r   <= px_nxt;
    s2_py_r   <= py_nxt;
  end

  // Per-axis floor, clamp and weights
  function automatic logic [35:0] axis_map(input logic signed [42:0] p,
                                           input logic [8:0] size);
    logic        in_img;
    logic [26:0] t;
    logic [9:0]  q, lo, hi, last;
    logic [16:0] f;
    logic [17:0] rem;
    logic [7:0]  w1;
    logic [8:0]  w0;
    in_img = !p[42] && (p[41:0] < {16'b0, size, 17'b0});
    t    = 27'(p[25:0]) + 27'd65536;
    q    = t[26:17];
    f    = t[16:0];
    last = {1'b0, size} - 10'd1;
    lo   = (q == 10'd0) ? 10'd0 : q - 10'd1;
    if (lo > last) lo = last;
    hi   = (q > last) ? last : q;
    rem  = 18'd131072 - {1'b0, f};
    w1   = f[16:9];
    w0   = rem[17:9];
    return {in_img, lo[8:0], hi[8:0], w0, w1};
  endfunction

  logic [35:0] mx, my;
  logic [8:0]  x0, x1, y0, y1, wx0, wy0;
  logic [7:0]  wx1, wy1;
  always_comb begin
    mx = axis_map(s2_px_r, src_width_r);
    my = axis_map(s2_py_r, src_height_r);
    {x0, x1, wx0, wx1} = mx[34:0];
    {y0, y1, wy0, wy1} = my[34:0];
  end

  // Stage 3: row bases and weight products
  logic           s3_vld_r, s3_in_r;
  in_item_t       s3_item_r;
  logic [15:0]    s3_rb0_r, s3_rb1_r;
  logic [8:0]     s3_x0_r, s3_x1_r;
  logic [16:0]    s3_t00_r, s3_t01_r, s3_t10_r, s3_t11_r;
  logic [17:0]    rb0_full, rb1_full;
  assign rb0_full = y0 * src_width_r;
  assign rb1_full = y1 * src_width_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else        s3_vld_r <= s2_vld_r;
    s3_item_r <= s2_item_r;
    s3_in_r   <= s2_ok_r && mx[35] && my[35];
    s3_rb0_r  <= rb0_full[15:0];
    s3_rb1_r  <= rb1_full[15:0];
    s3_x0_r   <= x0;
    s3_x1_r   <= x1;
    s3_t00_r  <= 17'(wy0 * wx0);
    s3_t01_r  <= 17'(wy0 * {1'b0, wx1});
    s3_t10_r  <= 17'({1'b0, wy1} * wx0);
    s3_t11_r  <= 17'({1'b0, wy1} * {1'b0, wx1});
  end

  // Frame store: four single-port copies, store writes all, render reads one each
  logic [STORE_AW-1:0] rd_addr [4];
  logic [23:0]         rd_data [4];
  logic                st_wr, st_rd;
  assign rd_addr[0] = s3_rb0_r + {7'b0, s3_x0_r};
  assign rd_addr[1] = s3_rb0_r + {7'b0, s3_x1_r};
  assign rd_addr[2] = s3_rb1_r + {7'b0, s3_x0_r};
  assign rd_addr[3] = s3_rb1_r + {7'b0, s3_x1_r};
  assign st_wr = s3_vld_r && (s3_item_r.action == ACT_STORE);
  assign st_rd = s3_vld_r && (s3_item_r.action == ACT_RENDER) && s3_in_r;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [23:0] mem [0:STORE_DEPTH-1];
    always_ff @(posedge clk) begin
      if (st_wr) begin
        mem[s3_item_r.source_index] <=
          {s3_item_r.byte_2, s3_item_r.byte_1, s3_item_r.byte_0};
      end else if (st_rd) begin
        rd_data[b] <= mem[rd_addr[b]];
      end
    end
  end

  // Stage 4: weights travel beside read data
  logic        s4_vld_r, s4_in_r;
  logic [16:0] s4_t_r [4];
  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else        s4_vld_r <= s3_vld_r && (s3_item_r.action == ACT_RENDER);
    s4_in_r   <= s3_in_r;
    s4_t_r[0] <= s3_t00_r;
    s4_t_r[1] <= s3_t01_r;
    s4_t_r[2] <= s3_t10_r;
    s4_t_r[3] <= s3_t11_r;
  end

  // Blend, format select, background
  logic       color_fmt;
  logic [7:0] pix [4][3];
  logic [26:0] acc [3];
  out_item_t  res_nxt;
  assign color_fmt = (bpp_r == 3'd3) || (bpp_r == 3'd4);
  always_comb begin
    for (int n = 0; n < 4; n++) begin
      for (int k = 0; k < 3; k++) begin
        pix[n][k] = color_fmt ? rd_data[n][8*k +: 8] : rd_data[n][7:0];
      end
    end
    for (int k = 0; k < 3; k++) begin
      acc[k] = 27'(pix[0][k] * s4_t_r[0]) + 27'(pix[1][k] * s4_t_r[1]) +
               27'(pix[2][k] * s4_t_r[2]) + 27'(pix[3][k] * s4_t_r[3]);
    end
    if (s4_in_r) begin
      res_nxt.pixel_color   = {8'hff, acc[2][23:16], acc[1][23:16], acc[0][23:16]};
      res_nxt.outside_image = 1'b0;
    end else begin
      res_nxt.pixel_color   = bg_color_r;
      res_nxt.outside_image = 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= s4_vld_r;
    out_item <= res_nxt;
  end

  // Checks
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_item.action == ACT_RENDER, 5))
    else $error("result without matching render transfer");
  a_bg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.outside_image) |-> (out_item.pixel_color == bg_color_r))
    else $error("background result carries wrong color");
  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.outside_image) |-> (out_item.pixel_color[31:24] == 8'hff))
    else $error("rendered pixel not opaque");

endmodule
`default_nettype wire
